[rtl/core/dtt_pkg.sv]
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants of the deadline timer table
// Item layouts, operation codes, sequencer states and table geometry.
// ----------------------------------------------------------------------------
package dtt_pkg;

  // Table geometry; the slot fields are four bits wide, so the table has 16 slots.
  localparam int SLOT_W = 4;
  localparam int SLOTS  = 1 << SLOT_W;
  localparam int CNT_W  = SLOT_W + 1;

  localparam logic [31:0] WINDOW_RESET = 32'd3600000;
  localparam logic [63:0] NONE_WAIT    = '1;

  // Operation codes.
  localparam logic [2:0] FN_ADD    = 3'd0;
  localparam logic [2:0] FN_CANCEL = 3'd1;
  localparam logic [2:0] FN_REFR   = 3'd2;
  localparam logic [2:0] FN_CHG    = 3'd3;
  localparam logic [2:0] FN_QUERY  = 3'd4;
  localparam logic [2:0] FN_EXPIRE = 3'd5;

  typedef struct packed {
    logic [2:0]        func;
    logic [63:0]       now_ms;
    logic [SLOT_W-1:0] slot_in;
    logic [63:0]       period_ms;
    logic              repeat_mode;
    logic              restart_from_now;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_out;
    logic [63:0]       wait_ms;
    logic              front_wake;
    logic              any_active;
    logic              expired_valid;
    logic              last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_OP, ST_SCAN, ST_RESCH, ST_RESW, ST_OUT
  } st_t;

  // What a pass over the table computes.
  typedef enum logic [1:0] {
    MD_FRONT, MD_QUERY, MD_DUE, MD_PICK
  } md_t;

endpackage

[rtl/core/deadline_timer_table_unit.sv]
// ----------------------------------------------------------------------------
// deadline_timer_table_unit: table of 16 software timers
// Add, cancel, refresh, change period, query next and expire, with expiry
// in deadline order and rescheduling of recurring timers.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------
//   input    | in_valid / in_stall  | in_data  (in_t)
//   result   | out_valid / out_stall| out_data (out_t)
//   config   | cfg_we               | cfg_wdata (32 b)
//
// Cancel, unknown codes, a full table, an inactive slot and expire on an
// empty table go straight to the result; refresh and change period without
// effect first read the slot. Add, query next and change period with effect
// make one pass over the deadline memory, one slot a cycle through its
// single read port. Expire makes one pass to mark the due timers, then one
// pass per due timer to pick the earliest, and rereads the interval of a
// recurring one to reschedule it. A result waits while out_stall is high.
// Reset is synchronous and clears marks and control state; the memories are
// not cleared. A stalled result holds the unit; one item is in work at a time.
// ----------------------------------------------------------------------------
module deadline_timer_table_unit
  import dtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  // Deadline and interval memories, one write and one registered read port.
  logic [63:0] dl_mem [SLOTS];
  logic [63:0] iv_mem [SLOTS];
  logic [SLOT_W-1:0] rd_addr, wr_addr;
  logic              dl_we, iv_we;
  logic [63:0]       dl_wd, iv_wd, dl_q, iv_q;

  st_t               state_r, state_nxt;
  md_t               mode_r, mode_nxt;
  logic [SLOTS-1:0]  active_r, active_nxt, rec_r, rec_nxt, due_r, due_nxt;
  logic              wake_r, wake_nxt;
  logic [63:0]       prev_r, prev_nxt;
  logic [31:0]       window_r;
  logic [2:0]        func_r, func_nxt;
  logic [63:0]       now_r, now_nxt, per_r, per_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt, tgt_r, tgt_nxt, bsl_r, bsl_nxt;
  logic              from_r, from_nxt, roll_r, roll_nxt;
  logic [63:0]       tds_r, tds_nxt, best_r, best_nxt;
  logic              found_r, found_nxt, fail_r, fail_nxt, fin_any_r, fin_any_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  out_t              res_r, res_nxt;
  logic [SLOT_W-1:0] free_slot, pv;
  logic [63:0]       start;

  // Memory ports.
  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[wr_addr] <= dl_wd;
    if (iv_we) iv_mem[wr_addr] <= iv_wd;
    dl_q <= dl_mem[rd_addr];
    iv_q <= iv_mem[rd_addr];
  end

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) free_slot = SLOT_W'(i);
    end
  end

  assign pv        = cnt_r[SLOT_W-1:0] - 1'b1;
  assign start     = from_r ? now_r : dl_q - iv_q;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = res_r;

  // Sequencer. Accesses to one entry never overlap: each write commits
  // before the following pass reads that entry.
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    active_nxt  = active_r;
    rec_nxt     = rec_r;
    due_nxt     = due_r;
    wake_nxt    = wake_r;
    prev_nxt    = prev_r;
    func_nxt    = func_r;
    now_nxt     = now_r;
    per_nxt     = per_r;
    slot_nxt    = slot_r;
    from_nxt    = from_r;
    roll_nxt    = roll_r;
    tgt_nxt     = tgt_r;
    tds_nxt     = tds_r;
    best_nxt    = best_r;
    bsl_nxt     = bsl_r;
    found_nxt   = found_r;
    fail_nxt    = fail_r;
    fin_any_nxt = fin_any_r;
    cnt_nxt     = cnt_r;
    res_nxt     = res_r;
    rd_addr     = cnt_r[SLOT_W-1:0];
    wr_addr     = slot_r;
    dl_we       = 1'b0;
    iv_we       = 1'b0;
    dl_wd       = '0;
    iv_wd       = '0;

    unique case (state_r)
      ST_IDLE: begin
        rd_addr = in_data.slot_in;
        if (in_valid) begin
          func_nxt = in_data.func;
          now_nxt  = in_data.now_ms;
          per_nxt  = in_data.period_ms;
          slot_nxt = in_data.slot_in;
          from_nxt = in_data.restart_from_now;
          mode_nxt = MD_QUERY;
          cnt_nxt  = '0;
          found_nxt = 1'b0;
          fail_nxt  = 1'b0;
          res_nxt  = '0;
          res_nxt.last = 1'b1;
          state_nxt = ST_OUT;
          unique case (in_data.func)
            FN_ADD: begin
              if (!(&active_r)) begin
                active_nxt[free_slot] = 1'b1;
                rec_nxt[free_slot]    = in_data.repeat_mode;
                wr_addr = free_slot;
                dl_we   = 1'b1;
                iv_we   = 1'b1;
                dl_wd   = in_data.now_ms + in_data.period_ms;
                iv_wd   = in_data.period_ms;
                tgt_nxt = free_slot;
                tds_nxt = in_data.now_ms + in_data.period_ms;
                res_nxt.ok       = 1'b1;
                res_nxt.slot_out = free_slot;
                mode_nxt  = MD_FRONT;
                state_nxt = ST_SCAN;
              end
            end
            FN_CANCEL: begin
              res_nxt.ok = active_r[in_data.slot_in];
              active_nxt[in_data.slot_in] = 1'b0;
            end
            FN_REFR, FN_CHG: begin
              if (active_r[in_data.slot_in]) state_nxt = ST_RD;
            end
            FN_QUERY: begin
              wake_nxt  = 1'b0;
              res_nxt.ok = 1'b1;
              state_nxt = ST_SCAN;
            end
            FN_EXPIRE: begin
              if (|active_r) begin
                roll_nxt = (in_data.now_ms < prev_r) &&
                           ((prev_r - in_data.now_ms) > {32'd0, window_r});
                prev_nxt  = in_data.now_ms;
                mode_nxt  = MD_DUE;
                state_nxt = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      // Read data for the addressed slot arrives here; the address is held
      // so that the data stays in place for the next state.
      ST_RD: begin
        rd_addr   = slot_r;
        state_nxt = ST_OP;
      end

      ST_OP: begin
        state_nxt = ST_OUT;
        if (func_r == FN_REFR) begin
          dl_we = 1'b1;
          dl_wd = now_r + iv_q;
          res_nxt.ok = 1'b1;
        end else if (!(per_r == iv_q && !from_r)) begin
          dl_we = 1'b1;
          iv_we = 1'b1;
          dl_wd = start + per_r;
          iv_wd = per_r;
          tgt_nxt = slot_r;
          tds_nxt = start + per_r;
          res_nxt.ok = 1'b1;
          mode_nxt  = MD_FRONT;
          state_nxt = ST_SCAN;
        end
      end

      // One slot a cycle: address cnt_r goes out, data of slot cnt_r-1 comes in.
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) begin
          unique case (mode_r)
            MD_FRONT: begin
              if (pv != tgt_r && active_r[pv] &&
                  !(tds_r < dl_q || (tds_r == dl_q && tgt_r < pv)))
                fail_nxt = 1'b1;
            end
            MD_QUERY: begin
              if (active_r[pv] && (!found_r || dl_q < best_r)) begin
                best_nxt  = dl_q;
                found_nxt = 1'b1;
              end
            end
            MD_DUE: begin
              due_nxt[pv] = active_r[pv] && (roll_r || dl_q <= now_r);
            end
            MD_PICK: begin
              if (due_r[pv] && (!found_r || dl_q < best_r)) begin
                best_nxt  = dl_q;
                bsl_nxt   = pv;
                found_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
        // Pass complete.
        if (cnt_r == CNT_W'(SLOTS)) begin
          state_nxt = ST_OUT;
          unique case (mode_r)
            MD_FRONT: begin
              res_nxt.front_wake = !fail_nxt && !wake_r;
              if (!fail_nxt) wake_nxt = 1'b1;
            end
            MD_QUERY: begin
              if (!found_nxt)            res_nxt.wait_ms = NONE_WAIT;
              else if (now_r >= best_nxt) res_nxt.wait_ms = '0;
              else                       res_nxt.wait_ms = best_nxt - now_r;
            end
            MD_DUE: begin
              res_nxt.ok  = 1'b1;
              fin_any_nxt = |(active_r & ~(due_nxt & ~rec_r));
              if (|due_nxt) begin
                mode_nxt  = MD_PICK;
                cnt_nxt   = '0;
                found_nxt = 1'b0;
                state_nxt = ST_SCAN;
              end
            end
            MD_PICK: begin
              due_nxt[bsl_nxt] = 1'b0;
              res_nxt.ok            = 1'b1;
              res_nxt.slot_out      = bsl_nxt;
              res_nxt.expired_valid = 1'b1;
              res_nxt.last          = ~|due_nxt;
              if (rec_r[bsl_nxt]) state_nxt = ST_RESCH;
              else active_nxt[bsl_nxt] = 1'b0;
            end
            default: ;
          endcase
        end
      end

      // Reschedule a recurring timer: read its interval, then write.
      ST_RESCH: begin
        rd_addr   = bsl_r;
        state_nxt = ST_RESW;
      end

      ST_RESW: begin
        wr_addr   = bsl_r;
        dl_we     = 1'b1;
        dl_wd     = now_r + iv_q;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_stall) begin
          if (mode_r == MD_PICK && (|due_r)) begin
            cnt_nxt   = '0;
            found_nxt = 1'b0;
            res_nxt   = '0;
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // The activity flag shows the table after the whole item.
    if (state_nxt == ST_OUT && state_r != ST_OUT)
      res_nxt.any_active = (mode_nxt == MD_PICK) ? fin_any_nxt : (|active_nxt);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mode_r   <= MD_QUERY;
      active_r <= '0;
      rec_r    <= '0;
      due_r    <= '0;
      wake_r   <= 1'b0;
      prev_r   <= '0;
      window_r <= WINDOW_RESET;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      active_r <= active_nxt;
      rec_r    <= rec_nxt;
      due_r    <= due_nxt;
      wake_r   <= wake_nxt;
      prev_r   <= prev_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_we) window_r <= cfg_wdata;
    end
  end

  // Item and working registers.
  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    now_r     <= now_nxt;
    per_r     <= per_nxt;
    slot_r    <= slot_nxt;
    from_r    <= from_nxt;
    roll_r    <= roll_nxt;
    tgt_r     <= tgt_nxt;
    tds_r     <= tds_nxt;
    best_r    <= best_nxt;
    bsl_r     <= bsl_nxt;
    found_r   <= found_nxt;
    fail_r    <= fail_nxt;
    fin_any_r <= fin_any_nxt;
    res_r     <= res_nxt;
  end

endmodule

[rtl/core/dtt_checker.sv]
// ----------------------------------------------------------------------------
// dtt_checker: port-level checks of the deadline timer table
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module dtt_checker
  import dtt_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // No item is taken while a result is waiting.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("item accepted while a result waits");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // More results of the same item keep the input closed.
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last) |=> in_stall)
    else $error("input opened before the final result");

  // An expired timer is always a success.
  a_exp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.expired_valid) |-> out_data.ok)
    else $error("expired result without ok");

endmodule

bind deadline_timer_table_unit dtt_checker u_dtt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
